### rtl/wav_riff_header_parser_macros.svh
// ============================================================================
// wav_riff_header_parser_macros.svh
// Assertion macros shared by the WAV header parser RTL.
// ============================================================================
`ifndef WAV_RIFF_HEADER_PARSER_MACROS_SVH
`define WAV_RIFF_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WRP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wrp assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WRP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wrp assertion failed: next-cycle implication");

`endif

### rtl/wrp_pkg.sv
// ============================================================================
// wrp_pkg
// Shared constants and types of the WAV header parser.
// ============================================================================
package wrp_pkg;

    // Chunk and file tags as they sit in the tag shifter (first byte lowest).
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam int unsigned TAG_BYTES       = 4;
    localparam int unsigned FMT_FIELD_BYTES = 16;

    localparam logic [15:0] FMT_PCM    = 16'd1;
    localparam logic [15:0] BITS_8     = 16'd8;
    localparam logic [15:0] BITS_16    = 16'd16;
    localparam logic [15:0] CH_MONO    = 16'd1;
    localparam logic [15:0] CH_STEREO  = 16'd2;

    // Result kinds
    localparam logic KIND_PCM    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Status codes
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_EOF_RIFF    = 4'd1;
    localparam logic [3:0] ST_BAD_RIFF    = 4'd2;
    localparam logic [3:0] ST_EOF_RSIZE   = 4'd3;
    localparam logic [3:0] ST_EOF_WAVE    = 4'd4;
    localparam logic [3:0] ST_BAD_WAVE    = 4'd5;
    localparam logic [3:0] ST_EOF_SIZE    = 4'd6;
    localparam logic [3:0] ST_EOF_FMT     = 4'd7;
    localparam logic [3:0] ST_EOF_DATA    = 4'd8;
    localparam logic [3:0] ST_NO_FMT      = 4'd9;
    localparam logic [3:0] ST_NO_DATA     = 4'd10;
    localparam logic [3:0] ST_NOT_PCM     = 4'd11;
    localparam logic [3:0] ST_BAD_BITS    = 4'd12;
    localparam logic [3:0] ST_BAD_CHANS   = 4'd13;
    localparam logic [3:0] ST_SHORT_FMT   = 4'd14;

    typedef struct packed {
        logic        kind;
        logic [7:0]  pcm_byte;
        logic [3:0]  status;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [15:0] bits_per_sample;
        logic        last;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } slot_t;

endpackage

### rtl/wrp_byte_if.sv
// ============================================================================
// wrp_byte_if
// Byte channel into the parser: one file byte and its end-of-file mark.
// ============================================================================
interface wrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_file;

    modport source (output valid, output in_byte, output end_of_file, input ready);
    modport sink   (input valid, input in_byte, input end_of_file, output ready);
endinterface

### rtl/wrp_result_if.sv
// ============================================================================
// wrp_result_if
// Result channel out of the parser: PCM bytes and the final status.
// ============================================================================
interface wrp_result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  pcm_byte;
    logic [3:0]  status;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic        last;

    modport source (
        output valid, output result_kind, output pcm_byte, output status,
        output channels, output sample_rate, output bits_per_sample, output last,
        input ready
    );
    modport sink (
        input valid, input result_kind, input pcm_byte, input status,
        input channels, input sample_rate, input bits_per_sample, input last,
        output ready
    );
endinterface

### rtl/wrp_parse_core.sv
// ============================================================================
// wrp_parse_core
// Parse state and per-byte next-state logic; yields up to two results.
// ============================================================================
`include "wav_riff_header_parser_macros.svh"

module wrp_parse_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  logic [7:0]     in_byte,
    input  logic           end_of_file,
    output wrp_pkg::slot_t slot_a,
    output wrp_pkg::slot_t slot_b
);
    import wrp_pkg::*;

    typedef enum logic [3:0] {
        PH_RIFF  = 4'd0,
        PH_RSIZE = 4'd1,
        PH_WAVE  = 4'd2,
        PH_ID    = 4'd3,
        PH_SIZE  = 4'd4,
        PH_FMT   = 4'd5,
        PH_DATA  = 4'd6,
        PH_SKIP  = 4'd7,
        PH_HALT  = 4'd8
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] length_reg, length_next;
    logic [15:0] format_reg, format_next;
    logic [15:0] chans_reg, chans_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic        seen_fmt_reg, seen_fmt_next;
    logic        seen_data_reg, seen_data_next;
    logic        pad_reg, pad_next;
    logic [3:0]  err_reg, err_next;

    logic [31:0] count_inc;
    logic        finish;
    logic        pcm_hit;
    logic [3:0]  st;
    result_t     pcm_res;
    result_t     st_res;

    // Field values after this byte, before the end-of-file clear.
    logic [31:0] rate_cap;
    logic [15:0] bits_cap;
    logic [15:0] chans_cap;

    assign count_inc = count_reg + 32'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        tag_next       = tag_reg;
        length_next    = length_reg;
        format_next    = format_reg;
        chans_next     = chans_reg;
        rate_next      = rate_reg;
        bits_next      = bits_reg;
        seen_fmt_next  = seen_fmt_reg;
        seen_data_next = seen_data_reg;
        pad_next       = pad_reg;
        err_next       = err_reg;
        finish         = 1'b0;
        pcm_hit        = 1'b0;
        st             = ST_OK;

        unique case (phase_reg)
            PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID:
            begin
                if (phase_reg == PH_ID && pad_reg)
                begin
                    pad_next = 1'b0;
                end
                else
                begin
                    tag_next   = {in_byte, tag_reg[31:8]};
                    count_next = count_inc;
                    if (count_inc == 32'(TAG_BYTES))
                    begin
                        count_next = '0;
                        if (phase_reg == PH_RIFF)
                        begin
                            if (tag_next != TAG_RIFF)
                            begin
                                if (err_next == ST_OK) err_next = ST_BAD_RIFF;
                                phase_next = PH_HALT;
                            end
                            else
                            begin
                                phase_next = PH_RSIZE;
                            end
                        end
                        else if (phase_reg == PH_RSIZE)
                        begin
                            phase_next = PH_WAVE;
                        end
                        else if (phase_reg == PH_WAVE)
                        begin
                            if (tag_next != TAG_WAVE)
                            begin
                                if (err_next == ST_OK) err_next = ST_BAD_WAVE;
                                phase_next = PH_HALT;
                            end
                            else
                            begin
                                tag_next   = '0;
                                phase_next = PH_ID;
                            end
                        end
                        else
                        begin
                            length_next = '0;
                            phase_next  = PH_SIZE;
                        end
                    end
                end
            end
            PH_SIZE:
            begin
                length_next = {in_byte, length_reg[31:8]};
                count_next  = count_inc;
                if (count_inc == 32'(TAG_BYTES))
                begin
                    count_next = '0;
                    if (tag_reg == TAG_FMT)
                    begin
                        seen_fmt_next = 1'b1;
                        format_next   = '0;
                        chans_next    = '0;
                        rate_next     = '0;
                        bits_next     = '0;
                        if (length_next < 32'(FMT_FIELD_BYTES) && err_next == ST_OK)
                            err_next = ST_SHORT_FMT;
                        phase_next = PH_FMT;
                    end
                    else if (tag_reg == TAG_DATA)
                    begin
                        seen_data_next = 1'b1;
                        phase_next     = PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                    finish = (length_next == '0);
                end
            end
            PH_FMT:
            begin
                // Capture the little-endian fields by their offset in the chunk.
                if (count_reg[31:4] == '0)
                begin
                    case (count_reg[3:0])
                        4'd0:    format_next[7:0]   = format_reg[7:0] | in_byte;
                        4'd1:    format_next[15:8]  = format_reg[15:8] | in_byte;
                        4'd2:    chans_next[7:0]    = chans_reg[7:0] | in_byte;
                        4'd3:    chans_next[15:8]   = chans_reg[15:8] | in_byte;
                        4'd4:    rate_next[7:0]     = rate_reg[7:0] | in_byte;
                        4'd5:    rate_next[15:8]    = rate_reg[15:8] | in_byte;
                        4'd6:    rate_next[23:16]   = rate_reg[23:16] | in_byte;
                        4'd7:    rate_next[31:24]   = rate_reg[31:24] | in_byte;
                        4'd14:   bits_next[7:0]     = bits_reg[7:0] | in_byte;
                        4'd15:   bits_next[15:8]    = bits_reg[15:8] | in_byte;
                        default: ;
                    endcase
                end
                count_next = count_inc;
                finish     = (count_inc == length_reg);
            end
            PH_DATA:
            begin
                pcm_hit    = 1'b1;
                count_next = count_inc;
                finish     = (count_inc == length_reg);
            end
            PH_SKIP:
            begin
                count_next = count_inc;
                finish     = (count_inc == length_reg);
            end
            PH_HALT:
            begin
                // Drop bytes until the end of the file.
            end
            default:
            begin
                phase_next = PH_HALT;
            end
        endcase

        if (finish)
        begin
            count_next = '0;
            tag_next   = '0;
            pad_next   = length_next[0];
            phase_next = PH_ID;
        end

        // Final checks in priority order; the first error latched wins.
        st = err_next;
        if (st == ST_OK)
        begin
            if (phase_next == PH_RIFF)
                st = ST_EOF_RIFF;
            else if (phase_next == PH_RSIZE)
                st = ST_EOF_RSIZE;
            else if (phase_next == PH_WAVE)
                st = ST_EOF_WAVE;
            else if (phase_next == PH_SIZE)
                st = ST_EOF_SIZE;
            else if (phase_next == PH_FMT && count_next < 32'(FMT_FIELD_BYTES))
                st = ST_EOF_FMT;
            else if (phase_next == PH_DATA)
                st = ST_EOF_DATA;
        end
        if (st == ST_OK && !seen_fmt_next)
            st = ST_NO_FMT;
        if (st == ST_OK && !seen_data_next)
            st = ST_NO_DATA;
        if (st == ST_OK && format_next != FMT_PCM)
            st = ST_NOT_PCM;
        if (st == ST_OK && bits_next != BITS_8 && bits_next != BITS_16)
            st = ST_BAD_BITS;
        if (st == ST_OK && chans_next != CH_MONO && chans_next != CH_STEREO)
            st = ST_BAD_CHANS;

        // The status fields are the values after this byte's capture.
        chans_cap = chans_next;
        rate_cap  = rate_next;
        bits_cap  = bits_next;

        // Return to the reset state after the final byte.
        if (end_of_file)
        begin
            phase_next     = PH_RIFF;
            count_next     = '0;
            tag_next       = '0;
            length_next    = '0;
            format_next    = '0;
            chans_next     = '0;
            rate_next      = '0;
            bits_next      = '0;
            seen_fmt_next  = 1'b0;
            seen_data_next = 1'b0;
            pad_next       = 1'b0;
            err_next       = ST_OK;
        end
    end

    always_comb
    begin
        pcm_res                 = '0;
        pcm_res.kind            = KIND_PCM;
        pcm_res.pcm_byte        = in_byte;

        st_res                  = '0;
        st_res.kind             = KIND_STATUS;
        st_res.status           = st;
        st_res.channels         = chans_cap;
        st_res.sample_rate      = rate_cap;
        st_res.bits_per_sample  = bits_cap;
        st_res.last             = 1'b1;

        slot_a = '0;
        slot_b = '0;
        if (pcm_hit)
        begin
            slot_a.valid = 1'b1;
            slot_a.data  = pcm_res;
            slot_b.valid = end_of_file;
            slot_b.data  = st_res;
        end
        else
        begin
            slot_a.valid = end_of_file;
            slot_a.data  = st_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_RIFF;
            count_reg     <= '0;
            tag_reg       <= '0;
            length_reg    <= '0;
            format_reg    <= '0;
            chans_reg     <= '0;
            rate_reg      <= '0;
            bits_reg      <= '0;
            seen_fmt_reg  <= 1'b0;
            seen_data_reg <= 1'b0;
            pad_reg       <= 1'b0;
            err_reg       <= ST_OK;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            tag_reg       <= tag_next;
            length_reg    <= length_next;
            format_reg    <= format_next;
            chans_reg     <= chans_next;
            rate_reg      <= rate_next;
            bits_reg      <= bits_next;
            seen_fmt_reg  <= seen_fmt_next;
            seen_data_reg <= seen_data_next;
            pad_reg       <= pad_next;
            err_reg       <= err_next;
        end
    end

    `WRP_ASSERT_IMP(a_pad_only_in_id, pad_reg, phase_reg == PH_ID)
    `WRP_ASSERT_IMP(a_tag_count_short,
        phase_reg == PH_RIFF || phase_reg == PH_RSIZE || phase_reg == PH_WAVE ||
        phase_reg == PH_ID || phase_reg == PH_SIZE,
        count_reg < 32'(TAG_BYTES))
    `WRP_ASSERT_NXT(a_eof_restarts, fire && end_of_file, phase_reg == PH_RIFF)

endmodule

### rtl/wrp_out_stage.sv
// ============================================================================
// wrp_out_stage
// Result register plus a one-entry stash for the second result of a byte.
// ============================================================================
`include "wav_riff_header_parser_macros.svh"

module wrp_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  wrp_pkg::slot_t slot_a,
    input  wrp_pkg::slot_t slot_b,
    output logic           space,
    wrp_result_if.source   result_ch
);
    import wrp_pkg::*;

    logic    out_valid_reg;
    logic    stash_valid_reg;
    result_t out_data_reg;
    result_t stash_data_reg;
    logic    out_free;

    assign out_free = !out_valid_reg || result_ch.ready;
    assign space    = !stash_valid_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            stash_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= slot_a.valid;
            if (slot_b.valid)
                stash_valid_reg <= 1'b1;
        end
        else if (stash_valid_reg && out_free)
        begin
            out_valid_reg   <= 1'b1;
            stash_valid_reg <= 1'b0;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (slot_a.valid)
                out_data_reg <= slot_a.data;
            if (slot_b.valid)
                stash_data_reg <= slot_b.data;
        end
        else if (stash_valid_reg && out_free)
        begin
            out_data_reg <= stash_data_reg;
        end
    end

    assign result_ch.valid           = out_valid_reg;
    assign result_ch.result_kind     = out_data_reg.kind;
    assign result_ch.pcm_byte        = out_data_reg.pcm_byte;
    assign result_ch.status          = out_data_reg.status;
    assign result_ch.channels        = out_data_reg.channels;
    assign result_ch.sample_rate     = out_data_reg.sample_rate;
    assign result_ch.bits_per_sample = out_data_reg.bits_per_sample;
    assign result_ch.last            = out_data_reg.last;

    `WRP_ASSERT_IMP(a_stash_behind_out, stash_valid_reg, out_valid_reg)
    `WRP_ASSERT_IMP(a_pair_is_pcm_then_status, fire && slot_b.valid,
        slot_a.valid && slot_a.data.kind == KIND_PCM && slot_b.data.last)
    `WRP_ASSERT_NXT(a_pair_fills_stash, fire && slot_b.valid, stash_valid_reg)

endmodule

### rtl/wav_riff_header_parser.sv
// ============================================================================
// wav_riff_header_parser
// Byte-serial WAV/RIFF header parser with PCM pass-through and final status.
// ============================================================================
// Usage:
//   byte_ch carries one file byte per transaction; end_of_file marks the last
//   byte of a file. result_ch carries one result per transaction: a PCM data
//   byte (result_kind 0) for every byte inside a data chunk, and one status
//   report (result_kind 1, last 1) after the final byte of the file.
//   Path: a byte accepted into the input register passes through the parse
//   core and is loaded into the result register once the output side has room.
//   Throughput: one byte per cycle while result_ch.ready stays high. The input
//   register and the parse core advance together; the only bubble is a final
//   byte inside a data chunk, which yields both a PCM byte and the status and
//   so holds the input while the stash drains.
//   Stall: when result_ch.ready is low the result register holds its
//   transaction, the input register fills, then byte_ch.ready drops.
//   Reset (rst_n low, asynchronous): parser returns to waiting for the RIFF
//   tag, all captured fields and the error code clear, both channels empty.
//   After each status report the parser is back in that state for a new file.
// ============================================================================
module wav_riff_header_parser (
    input  logic         clk,
    input  logic         rst_n,
    wrp_byte_if.sink     byte_ch,
    wrp_result_if.source result_ch
);
    import wrp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eof_reg;
    logic       space;
    logic       fire;
    slot_t      slot_a;
    slot_t      slot_b;

    // Advance the held byte through the parser when the output side has room.
    assign fire          = in_valid_reg && space;
    assign byte_ch.ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_ch.valid && byte_ch.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Payload of the input register; loaded on every accepted transaction.
    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
        begin
            in_byte_reg <= byte_ch.in_byte;
            in_eof_reg  <= byte_ch.end_of_file;
        end
    end

    wrp_parse_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .in_byte     (in_byte_reg),
        .end_of_file (in_eof_reg),
        .slot_a      (slot_a),
        .slot_b      (slot_b)
    );

    wrp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .slot_a    (slot_a),
        .slot_b    (slot_b),
        .space     (space),
        .result_ch (result_ch)
    );

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the byte-serial WAV header parser.
// Feeds whole WAV files, broken files and noise one byte per transaction,
// predicts every PCM byte and every status report, and compares each result
// field by field while both channels idle and stall at random.
// ============================================================================

import wrp_pkg::*;

typedef enum logic [3:0] {
    SEEK_RIFF, SEEK_RSIZE, SEEK_WAVE, SEEK_ID, GET_SIZE,
    GET_FMT, PASS_DATA, SKIP_BODY, HALTED
} wav_phase_e;

class wav_stream_tracker;
    wav_phase_e  phase;
    logic [31:0] pos;
    logic [31:0] tag_sr;
    logic [31:0] chunk_len;
    logic [15:0] fmt_code;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bits;
    bit          fmt_seen;
    bit          data_seen;
    bit          pad_due;
    logic [3:0]  first_error;
    result_t     expected_results[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
        clear();
        mismatches = 0;
        checked = 0;
    endfunction

    function void clear();
        phase = SEEK_RIFF;
        pos = '0;
        tag_sr = '0;
        chunk_len = '0;
        fmt_code = '0;
        chans = '0;
        rate = '0;
        bits = '0;
        fmt_seen = 1'b0;
        data_seen = 1'b0;
        pad_due = 1'b0;
        first_error = ST_OK;
    endfunction

    // Keep only the first error of a file.
    function void flag(logic [3:0] code);
        if (first_error == ST_OK)
            first_error = code;
    endfunction

    function void close_chunk();
        pos = '0;
        tag_sr = '0;
        pad_due = chunk_len[0];
        phase = SEEK_ID;
    endfunction

    function void absorb_byte(logic [7:0] b, logic eof);
        result_t r;
        case (phase)
            SEEK_RIFF, SEEK_RSIZE, SEEK_WAVE, SEEK_ID:
            begin
                if (phase == SEEK_ID && pad_due)
                begin
                    pad_due = 1'b0;
                end
                else
                begin
                    tag_sr = {b, tag_sr[31:8]};
                    pos = pos + 1;
                    if (pos == TAG_BYTES)
                    begin
                        pos = '0;
                        case (phase)
                            SEEK_RIFF:
                            begin
                                if (tag_sr != TAG_RIFF)
                                begin
                                    flag(ST_BAD_RIFF);
                                    phase = HALTED;
                                end
                                else
                                begin
                                    phase = SEEK_RSIZE;
                                end
                            end
                            SEEK_RSIZE: phase = SEEK_WAVE;
                            SEEK_WAVE:
                            begin
                                if (tag_sr != TAG_WAVE)
                                begin
                                    flag(ST_BAD_WAVE);
                                    phase = HALTED;
                                end
                                else
                                begin
                                    tag_sr = '0;
                                    phase = SEEK_ID;
                                end
                            end
                            default:
                            begin
                                chunk_len = '0;
                                phase = GET_SIZE;
                            end
                        endcase
                    end
                end
            end
            GET_SIZE:
            begin
                chunk_len = {b, chunk_len[31:8]};
                pos = pos + 1;
                if (pos == TAG_BYTES)
                begin
                    pos = '0;
                    if (tag_sr == TAG_FMT)
                    begin
                        // A new fmt chunk wipes whatever an earlier one left.
                        fmt_seen = 1'b1;
                        fmt_code = '0;
                        chans = '0;
                        rate = '0;
                        bits = '0;
                        if (chunk_len < FMT_FIELD_BYTES)
                            flag(ST_SHORT_FMT);
                        phase = GET_FMT;
                    end
                    else if (tag_sr == TAG_DATA)
                    begin
                        data_seen = 1'b1;
                        phase = PASS_DATA;
                    end
                    else
                    begin
                        phase = SKIP_BODY;
                    end
                    if (chunk_len == 0)
                        close_chunk();
                end
            end
            GET_FMT:
            begin
                if (pos < 2)
                    fmt_code = fmt_code | ({8'd0, b} << (8 * pos));
                else if (pos < 4)
                    chans = chans | ({8'd0, b} << (8 * (pos - 2)));
                else if (pos < 8)
                    rate = rate | ({24'd0, b} << (8 * (pos - 4)));
                else if (pos == 14 || pos == 15)
                    bits = bits | ({8'd0, b} << (8 * (pos - 14)));
                pos = pos + 1;
                if (pos == chunk_len)
                    close_chunk();
            end
            PASS_DATA:
            begin
                r = '0;
                r.kind = KIND_PCM;
                r.pcm_byte = b;
                expected_results.push_back(r);
                pos = pos + 1;
                if (pos == chunk_len)
                    close_chunk();
            end
            SKIP_BODY:
            begin
                pos = pos + 1;
                if (pos == chunk_len)
                    close_chunk();
            end
            default: ;
        endcase

        if (eof)
        begin
            case (phase)
                SEEK_RIFF:  flag(ST_EOF_RIFF);
                SEEK_RSIZE: flag(ST_EOF_RSIZE);
                SEEK_WAVE:  flag(ST_EOF_WAVE);
                GET_SIZE:   flag(ST_EOF_SIZE);
                GET_FMT:    if (pos < FMT_FIELD_BYTES) flag(ST_EOF_FMT);
                PASS_DATA:  flag(ST_EOF_DATA);
                default: ;
            endcase
            if (!fmt_seen)
                flag(ST_NO_FMT);
            if (!data_seen)
                flag(ST_NO_DATA);
            if (fmt_code != FMT_PCM)
                flag(ST_NOT_PCM);
            if (bits != BITS_8 && bits != BITS_16)
                flag(ST_BAD_BITS);
            if (chans != CH_MONO && chans != CH_STEREO)
                flag(ST_BAD_CHANS);
            r.kind = KIND_STATUS;
            r.pcm_byte = '0;
            r.status = first_error;
            r.channels = chans;
            r.sample_rate = rate;
            r.bits_per_sample = bits;
            r.last = 1'b1;
            expected_results.push_back(r);
            clear();
        end
    endfunction

    task report(string msg);
        mismatches++;
        if (mismatches <= 50)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare_result(result_t got);
        result_t want;
        checked++;
        if (expected_results.size() == 0)
        begin
            report($sformatf("result %0d (kind %0d) arrived with nothing pending",
                             checked, got.kind));
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.kind != want.kind)
                report($sformatf("result %0d kind %0d, want %0d",
                                 checked, got.kind, want.kind));
            if (got.pcm_byte != want.pcm_byte)
                report($sformatf("result %0d pcm_byte 0x%0h, want 0x%0h",
                                 checked, got.pcm_byte, want.pcm_byte));
            if (got.status != want.status)
                report($sformatf("result %0d status %0d, want %0d",
                                 checked, got.status, want.status));
            if (got.channels != want.channels)
                report($sformatf("result %0d channels %0d, want %0d",
                                 checked, got.channels, want.channels));
            if (got.sample_rate != want.sample_rate)
                report($sformatf("result %0d sample_rate %0d, want %0d",
                                 checked, got.sample_rate, want.sample_rate));
            if (got.bits_per_sample != want.bits_per_sample)
                report($sformatf("result %0d bits_per_sample %0d, want %0d",
                                 checked, got.bits_per_sample, want.bits_per_sample));
            if (got.last != want.last)
                report($sformatf("result %0d last %0d, want %0d",
                                 checked, got.last, want.last));
        end
    endtask
endclass

module tb;

    localparam int unsigned RANDOM_BYTES   = 1000;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned HOLD_AFTER_PCM = 40;
    localparam int unsigned HOLD_CYCLES    = 400;

    logic clk;
    logic rst_n;

    wrp_byte_if   byte_ch ();
    wrp_result_if result_ch ();

    wav_riff_header_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .result_ch (result_ch)
    );

    wav_stream_tracker tracker;
    logic [7:0]        file_bytes[$];
    int unsigned       bytes_sent;
    int unsigned       pcm_results;
    int unsigned       cycle_count;
    bit                rx_hold;
    bit                hold_done;

    // Free-running 100 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a run that hangs or loses a result ends here.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Mostly no pause, sometimes a short one, now and then a long one.
    function automatic int unsigned random_pause();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        else if (r < 18)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Append the low bytes of a value, least significant first, as RIFF stores them.
    task automatic put_le(logic [31:0] value, int unsigned count);
        for (int k = 0; k < count; k++)
            file_bytes.push_back(value[8 * k +: 8]);
    endtask

    // Append a complete chunk with a random body and its pad byte if odd.
    task automatic put_chunk(logic [31:0] id, int unsigned len);
        put_le(id, 4);
        put_le(len, 4);
        repeat (len) file_bytes.push_back(8'($urandom));
        if (len % 2 == 1)
            file_bytes.push_back(8'($urandom));
    endtask

    // Build a WAV file with random content: mostly well formed, with the
    // occasional missing or repeated fmt, short or long fmt, no data, extra
    // chunks, and an ending that is cut, corrupted or left inside a chunk.
    task automatic build_wav_file();
        int unsigned  fmt_len;
        int unsigned  copies;
        int unsigned  n_data;
        int unsigned  cut;
        int unsigned  idx;
        logic [15:0]  fmt_tag;
        logic [15:0]  chan_field;
        logic [15:0]  bits_field;
        logic [31:0]  rate_field;
        logic [31:0]  open_id;
        logic [127:0] fields;
        file_bytes.delete();
        put_le(TAG_RIFF, 4);
        put_le($urandom, 4);
        put_le(TAG_WAVE, 4);
        if ($urandom_range(0, 3) == 0)
            put_chunk($urandom, $urandom_range(0, 7));

        copies = ($urandom_range(0, 15) == 0) ? 0 : (($urandom_range(0, 9) == 0) ? 2 : 1);
        repeat (copies)
        begin
            case ($urandom_range(0, 9))
                0:       fmt_len = $urandom_range(0, 15);
                1, 2:    fmt_len = FMT_FIELD_BYTES + $urandom_range(1, 5);
                default: fmt_len = FMT_FIELD_BYTES;
            endcase
            fmt_tag = ($urandom_range(0, 7) == 0) ? 16'($urandom) : FMT_PCM;
            case ($urandom_range(0, 9))
                0:       chan_field = 16'($urandom);
                1:       chan_field = 16'hFFFF;
                2, 3, 4: chan_field = CH_MONO;
                default: chan_field = CH_STEREO;
            endcase
            case ($urandom_range(0, 5))
                0:       rate_field = 32'd8000;
                1:       rate_field = 32'd44100;
                2:       rate_field = 32'd48000;
                3:       rate_field = 32'd0;
                4:       rate_field = 32'hFFFF_FFFF;
                default: rate_field = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0:       bits_field = 16'($urandom);
                1:       bits_field = 16'd24;
                2, 3, 4: bits_field = BITS_8;
                default: bits_field = BITS_16;
            endcase
            // Field layout, lowest byte first: format, channels, rate,
            // byte rate, block align, bits per sample.
            fields = {bits_field, 16'($urandom), $urandom, rate_field, chan_field, fmt_tag};
            put_le(TAG_FMT, 4);
            put_le(fmt_len, 4);
            for (int k = 0; k < fmt_len; k++)
            begin
                if (k < FMT_FIELD_BYTES)
                    file_bytes.push_back(fields[8 * k +: 8]);
                else
                    file_bytes.push_back(8'($urandom));
            end
            if (fmt_len % 2 == 1)
                file_bytes.push_back(8'($urandom));
        end

        n_data = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        repeat (n_data)
        begin
            put_chunk(TAG_DATA, $urandom_range(0, 16));
            if ($urandom_range(0, 4) == 0)
                put_chunk($urandom, $urandom_range(0, 5));
        end

        case ($urandom_range(0, 9))
            0, 1:
            begin
                cut = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > cut)
                    void'(file_bytes.pop_back());
            end
            2:
            begin
                // Aim half the time at the file tags and RIFF size, otherwise anywhere.
                if ($urandom_range(0, 1) == 0)
                    idx = $urandom_range(0, 11);
                else
                    idx = $urandom_range(0, file_bytes.size() - 1);
                file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
            end
            3:
            begin
                // Leave the file inside a chunk whose size is far too big.
                case ($urandom_range(0, 2))
                    0:       open_id = TAG_DATA;
                    1:       open_id = TAG_FMT;
                    default: open_id = $urandom;
                endcase
                put_le(open_id, 4);
                put_le($urandom | 32'h0100_0000, 4);
                repeat ($urandom_range(0, 20)) file_bytes.push_back(8'($urandom));
            end
            default: ;
        endcase
    endtask

    task automatic build_noise_file();
        file_bytes.delete();
        if ($urandom_range(0, 1) == 0)
            put_le(TAG_RIFF, 4);
        repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom));
    endtask

    // Offer the file byte by byte; mark the last one as end of file.
    task automatic send_file(bit steady);
        int unsigned gap;
        logic        eof;
        for (int i = 0; i < file_bytes.size(); i++)
        begin
            eof = (i == file_bytes.size() - 1);
            gap = (steady || rx_hold) ? 0 : random_pause();
            if (gap != 0)
            begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            byte_ch.valid       <= 1'b1;
            byte_ch.in_byte     <= file_bytes[i];
            byte_ch.end_of_file <= eof;
            do
                @(posedge clk);
            while (!byte_ch.ready);
            tracker.absorb_byte(file_bytes[i], eof);
            bytes_sent++;
        end
    endtask

    // Result side: accept in random runs, and once hold off long enough
    // that the parser backs up and drops its byte ready.
    initial
    begin
        int unsigned pause;
        result_ch.ready = 1'b0;
        rx_hold = 1'b0;
        hold_done = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!hold_done && pcm_results >= HOLD_AFTER_PCM)
            begin
                hold_done = 1'b1;
                rx_hold = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            pause = random_pause();
            if (pause != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
        end
    end

    // Check every result transaction against the oldest prediction.
    initial
    begin
        pcm_results = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                tracker.compare_result(result_t'({result_ch.result_kind, result_ch.pcm_byte,
                                                  result_ch.status, result_ch.channels,
                                                  result_ch.sample_rate,
                                                  result_ch.bits_per_sample,
                                                  result_ch.last}));
                if (result_ch.result_kind == KIND_PCM)
                    pcm_results++;
            end
        end
    end

    // Main sequence: reset, directed files, random files, drain, verdict.
    initial
    begin
        tracker = new();
        bytes_sent = 0;
        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.in_byte = 8'h00;
        byte_ch.end_of_file = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // File of one zero byte: ends inside the RIFF tag.
        file_bytes = '{8'h00};
        send_file(1'b1);
        // All-ones tag: not RIFF.
        file_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_file(1'b1);
        // Ends inside the RIFF size.
        file_bytes.delete();
        put_le(TAG_RIFF, 4);
        put_le(32'h0000_FFFF, 2);
        send_file(1'b0);
        // Ends inside the WAVE tag.
        file_bytes.delete();
        put_le(TAG_RIFF, 4);
        put_le(32'hFFFF_FFFF, 4);
        put_le(TAG_WAVE, 2);
        send_file(1'b0);

        while (bytes_sent < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 4) == 0)
                build_noise_file();
            else
                build_wav_file();
            send_file($urandom_range(0, 3) == 0);
        end
        byte_ch.valid <= 1'b0;

        // Drain what is still in flight, then give stray results a chance.
        while (tracker.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
